@@ rtl/two_colour_cell_split_defines.svh @@
// Assertion macros for the cell splitter
`ifndef TWO_COLOUR_CELL_SPLIT_DEFINES_SVH
`define TWO_COLOUR_CELL_SPLIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TCS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define TCS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define TCS_ASSERT(label, clk, rst_n, prop)
`define TCS_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ rtl/tcs_pkg.sv @@
`timescale 1ns / 1ps
package tcs_pkg;
    localparam int NumPix = 6;
    localparam int NumStages = 6;

    typedef logic [24:0] t_pix;
    typedef logic [23:0] t_rgb;

    typedef enum logic [1:0] {
        KIND_BLANK = 2'd0,
        KIND_MIXED = 2'd1,
        KIND_SPLIT = 2'd2
    } t_kind;

    localparam logic [1:0] STYLE_QUAD   = 2'd0;
    localparam logic [1:0] STYLE_TRI    = 2'd1;
    localparam logic [1:0] STYLE_SEXT   = 2'd2;

    typedef struct packed {
        t_pix [NumPix-1:0] sub_pixel;
    } t_in_word;

    typedef struct packed {
        t_kind       cell_kind;
        logic [5:0]  fill_mask;
        logic        corner_glyph;
        t_rgb        fore_colour;
        t_rgb        back_colour;
        logic [7:0]  fore_palette;
        logic [7:0]  back_palette;
    } t_out_word;

    function automatic logic [16:0] luma(input t_rgb c);
        luma = 17'(30 * c[23:16]) + 17'(59 * c[15:8]) + 17'(11 * c[7:0]);
    endfunction

    function automatic logic [15:0] sqd(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? a - b : b - a;
        sqd = 16'(d) * 16'(d);
    endfunction

    function automatic logic [17:0] rgb_dist(input t_rgb a, input t_rgb b);
        rgb_dist = 18'(sqd(a[23:16], b[23:16])) + 18'(sqd(a[15:8], b[15:8]))
                 + 18'(sqd(a[7:0], b[7:0]));
    endfunction

    // nearest cube level, ties to lower
    function automatic logic [2:0] cube_idx(input logic [7:0] v);
        if (v < 8'd48)       cube_idx = 3'd0;
        else if (v < 8'd116) cube_idx = 3'd1;
        else if (v < 8'd156) cube_idx = 3'd2;
        else if (v < 8'd196) cube_idx = 3'd3;
        else if (v < 8'd236) cube_idx = 3'd4;
        else                 cube_idx = 3'd5;
    endfunction

    function automatic logic [7:0] cube_lvl(input logic [2:0] i);
        case (i)
            3'd0: cube_lvl = 8'd0;
            3'd1: cube_lvl = 8'd95;
            3'd2: cube_lvl = 8'd135;
            3'd3: cube_lvl = 8'd175;
            3'd4: cube_lvl = 8'd215;
            default: cube_lvl = 8'd255;
        endcase
    endfunction

    // sum over 3 lanes, value below 768
    function automatic logic [7:0] div3(input logic [9:0] s);
        logic [19:0] p;
        p = 20'(s) * 20'd683;
        div3 = p[18:11];
    endfunction

    // divide a channel sum (up to 6*255) by a count 1..6
    function automatic logic [7:0] divn(input logic [10:0] s, input logic [2:0] n);
        logic [23:0] p;
        case (n)
            3'd1: divn = s[7:0];
            3'd2: divn = s[8:1];
            3'd3: begin p = 24'(s) * 24'd2731; divn = p[20:13]; end
            3'd4: divn = s[9:2];
            3'd5: begin p = 24'(s) * 24'd3277; divn = p[21:14]; end
            3'd6: begin p = 24'(s) * 24'd2731; divn = p[21:14]; end
            default: divn = 8'd0;
        endcase
    endfunction
endpackage

@@ rtl/tcs_if.sv @@
`timescale 1ns / 1ps
interface tcs_in_if;
    logic              valid;
    logic              ready;
    tcs_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tcs_out_if;
    logic               valid;
    logic               ready;
    tcs_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/two_colour_cell_split.sv @@
`timescale 1ns / 1ps
// Two-colour splitter for one character cell.
// i_cell: one word per cell, six 25-bit sub-pixels (bit 24 transparent).
// o_cell: one word per cell: kind, mask, corner flag, two colours and
//   their xterm-256 indexes.
// i_style_we / i_style_wdata set the cell style; write only while idle.
// Each cell passes through six registered stages: seed search, distance,
// cluster sums, means, palette pre-compute and palette select. One cell is
// accepted every cycle while the receiver does not stall the pipeline.
// All stages advance together; a stalled receiver holds every stage and
// drops i_cell.ready only when the last stage is full and not taken, so
// nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and sets style 0.
`include "two_colour_cell_split_defines.svh"
module two_colour_cell_split (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_style_we,
    input  logic [1:0] i_style_wdata,
    tcs_in_if.sink     i_cell,
    tcs_out_if.source  o_cell
);
    logic [1:0]                    r_style;
    logic [tcs_pkg::NumStages-1:0] r_vld;
    logic                          adv;

    assign adv          = !r_vld[tcs_pkg::NumStages-1] || o_cell.ready;
    assign i_cell.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_style <= tcs_pkg::STYLE_QUAD;
            r_vld   <= '0;
        end else begin
            if (i_style_we) r_style <= i_style_wdata;
            if (adv) r_vld <= {r_vld[tcs_pkg::NumStages-2:0], i_cell.valid};
        end
    end

    // ---- stage 1: unpack, transparency, seeds
    logic       n_six;
    logic [5:0] n_opq, n_use;
    tcs_pkg::t_rgb [5:0] n_rgb;
    logic [16:0] lu [6];
    logic [2:0]  n_hi, n_lo;
    always_comb begin
        n_six = (r_style == tcs_pkg::STYLE_SEXT);
        n_use = n_six ? 6'h3F : 6'h0F;
        n_hi = 3'd0;
        n_lo = 3'd0;
        for (int i = 0; i < 6; i++) begin
            n_rgb[i] = i_cell.data.sub_pixel[i][23:0];
            n_opq[i] = !i_cell.data.sub_pixel[i][24] && n_use[i];
            lu[i]    = tcs_pkg::luma(n_rgb[i]);
        end
        for (int i = 1; i < 6; i++) begin
            if (n_use[i] && lu[i] > lu[n_hi]) n_hi = 3'(i);
            if (n_use[i] && lu[i] < lu[n_lo]) n_lo = 3'(i);
        end
    end

    tcs_pkg::t_rgb [5:0] r_s1_rgb;
    logic [5:0] r_s1_opq, r_s1_use;
    logic [1:0] r_s1_sty;
    tcs_pkg::t_rgb r_s1_sf, r_s1_sb;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_rgb <= n_rgb;
            r_s1_opq <= n_opq;
            r_s1_use <= n_use;
            r_s1_sty <= r_style;
            r_s1_sf  <= n_rgb[n_hi];
            r_s1_sb  <= n_rgb[n_lo];
        end
    end

    // ---- stage 2: sides and kind
    logic [5:0] n_s2_side;
    tcs_pkg::t_kind n_s2_kind;
    always_comb begin
        for (int i = 0; i < 6; i++)
            n_s2_side[i] = r_s1_use[i] &&
                (tcs_pkg::rgb_dist(r_s1_rgb[i], r_s1_sf)
                 < tcs_pkg::rgb_dist(r_s1_rgb[i], r_s1_sb));
        if (r_s1_opq == '0)            n_s2_kind = tcs_pkg::KIND_BLANK;
        else if (r_s1_opq != r_s1_use) n_s2_kind = tcs_pkg::KIND_MIXED;
        else                           n_s2_kind = tcs_pkg::KIND_SPLIT;
    end

    tcs_pkg::t_rgb [5:0] r_s2_rgb;
    logic [5:0] r_s2_use, r_s2_mask;
    logic [1:0] r_s2_sty;
    tcs_pkg::t_kind r_s2_kind;
    tcs_pkg::t_rgb r_s2_sf;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_rgb  <= r_s1_rgb;
            r_s2_use  <= r_s1_use;
            r_s2_sty  <= r_s1_sty;
            r_s2_kind <= n_s2_kind;
            r_s2_sf   <= r_s1_sf;
            r_s2_mask <= (n_s2_kind == tcs_pkg::KIND_SPLIT) ? n_s2_side : r_s1_opq;
        end
    end

    // ---- stage 3: cluster sums (fore = mask set, back = rest of used)
    logic [10:0] n_s3_fs [3];
    logic [10:0] n_s3_bs [3];
    logic [2:0]  n_s3_fc, n_s3_bc;
    always_comb begin
        n_s3_fc = '0;
        n_s3_bc = '0;
        for (int c = 0; c < 3; c++) begin
            n_s3_fs[c] = '0;
            n_s3_bs[c] = '0;
        end
        for (int i = 0; i < 6; i++) begin
            if (r_s2_mask[i]) begin
                n_s3_fc = n_s3_fc + 3'd1;
                for (int c = 0; c < 3; c++)
                    n_s3_fs[c] = n_s3_fs[c] + 11'(r_s2_rgb[i][8*c +: 8]);
            end else if (r_s2_use[i]) begin
                n_s3_bc = n_s3_bc + 3'd1;
                for (int c = 0; c < 3; c++)
                    n_s3_bs[c] = n_s3_bs[c] + 11'(r_s2_rgb[i][8*c +: 8]);
            end
        end
    end

    logic [10:0] r_s3_fs [3];
    logic [10:0] r_s3_bs [3];
    logic [2:0]  r_s3_fc, r_s3_bc;
    logic [5:0]  r_s3_mask;
    logic [1:0]  r_s3_sty;
    tcs_pkg::t_kind r_s3_kind;
    tcs_pkg::t_rgb r_s3_sf;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_fs   <= n_s3_fs;
            r_s3_bs   <= n_s3_bs;
            r_s3_fc   <= n_s3_fc;
            r_s3_bc   <= n_s3_bc;
            r_s3_mask <= r_s2_mask;
            r_s3_sty  <= r_s2_sty;
            r_s3_kind <= r_s2_kind;
            r_s3_sf   <= r_s2_sf;
        end
    end

    // ---- stage 4: means, corner, swap
    tcs_pkg::t_rgb n_s4_f, n_s4_b, fm, bm;
    logic n_s4_cor, lone_fg, lone_bg;
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            fm[8*c +: 8] = tcs_pkg::divn(r_s3_fs[c], r_s3_fc);
            bm[8*c +: 8] = tcs_pkg::divn(r_s3_bs[c], r_s3_bc);
        end
        lone_fg = (r_s3_mask == 6'd1) || (r_s3_mask == 6'd2) || (r_s3_mask == 6'd4)
               || (r_s3_mask == 6'd8);
        lone_bg = (r_s3_mask == 6'd7) || (r_s3_mask == 6'd11) || (r_s3_mask == 6'd13)
               || (r_s3_mask == 6'd14);
        n_s4_cor = 1'b0;
        n_s4_f   = '0;
        n_s4_b   = '0;
        case (r_s3_kind)
            tcs_pkg::KIND_MIXED: n_s4_f = fm;
            tcs_pkg::KIND_SPLIT: begin
                n_s4_f = (r_s3_fc != '0) ? fm : r_s3_sf;
                n_s4_b = bm;
                if (r_s3_sty == tcs_pkg::STYLE_TRI) begin
                    n_s4_cor = lone_fg || lone_bg;
                    if (lone_bg) begin
                        n_s4_f = bm;
                        n_s4_b = (r_s3_fc != '0) ? fm : r_s3_sf;
                    end
                end
            end
            default: ;
        endcase
    end

    tcs_pkg::t_rgb r_s4_f, r_s4_b;
    logic r_s4_cor;
    logic [5:0] r_s4_mask;
    tcs_pkg::t_kind r_s4_kind;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s4_f    <= n_s4_f;
            r_s4_b    <= n_s4_b;
            r_s4_cor  <= n_s4_cor;
            r_s4_mask <= r_s3_mask;
            r_s4_kind <= r_s3_kind;
        end
    end

    // ---- stage 5: palette pre-compute for both colours
    logic [2:0]  n_s5_ci [2][3];
    logic [17:0] n_s5_dc [2];
    logic        n_s5_gr [2];
    logic [7:0]  n_s5_g [2];
    tcs_pkg::t_rgb col [2];
    logic [7:0] dd1, dd2;
    always_comb begin
        col[0] = r_s4_f;
        col[1] = r_s4_b;
        for (int k = 0; k < 2; k++) begin
            n_s5_dc[k] = '0;
            for (int c = 0; c < 3; c++) begin
                n_s5_ci[k][c] = tcs_pkg::cube_idx(col[k][8*c +: 8]);
                n_s5_dc[k] = n_s5_dc[k] + 18'(tcs_pkg::sqd(col[k][8*c +: 8],
                                                tcs_pkg::cube_lvl(n_s5_ci[k][c])));
            end
            dd1 = (col[k][23:16] > col[k][15:8]) ? col[k][23:16] - col[k][15:8]
                                                 : col[k][15:8] - col[k][23:16];
            dd2 = (col[k][15:8] > col[k][7:0]) ? col[k][15:8] - col[k][7:0]
                                               : col[k][7:0] - col[k][15:8];
            n_s5_gr[k] = (dd1 < 8'd8) && (dd2 < 8'd8);
            n_s5_g[k]  = tcs_pkg::div3(10'(col[k][23:16]) + 10'(col[k][15:8])
                                       + 10'(col[k][7:0]));
        end
    end

    logic [2:0]  r_s5_ci [2][3];
    logic [17:0] r_s5_dc [2];
    logic        r_s5_gr [2];
    logic [7:0]  r_s5_g [2];
    tcs_pkg::t_rgb r_s5_f, r_s5_b;
    logic r_s5_cor;
    logic [5:0] r_s5_mask;
    tcs_pkg::t_kind r_s5_kind;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s5_ci   <= n_s5_ci;
            r_s5_dc   <= n_s5_dc;
            r_s5_gr   <= n_s5_gr;
            r_s5_g    <= n_s5_g;
            r_s5_f    <= r_s4_f;
            r_s5_b    <= r_s4_b;
            r_s5_cor  <= r_s4_cor;
            r_s5_mask <= r_s4_mask;
            r_s5_kind <= r_s4_kind;
        end
    end

    // ---- stage 6: gray ramp versus cube
    logic [7:0] n_s6_pal [2];
    logic [4:0] gk;
    logic [7:0] gl, gd;
    logic [17:0] dg3;
    logic [7:0] cube;
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            gk = '0;
            for (int j = 1; j < 24; j++)
                if (r_s5_g[k] >= 8'(8 + 10 * j)) gk = 5'(j);
            gl  = 8'd8 + 8'(gk) * 8'd10;
            gd  = (r_s5_g[k] > gl) ? r_s5_g[k] - gl : gl - r_s5_g[k];
            dg3 = 18'(gd) * 18'(gd) * 18'd3;
            cube = 8'd16 + 8'(r_s5_ci[k][2]) * 8'd36 + 8'(r_s5_ci[k][1]) * 8'd6
                 + 8'(r_s5_ci[k][0]);
            n_s6_pal[k] = (r_s5_gr[k] && dg3 < r_s5_dc[k]) ? 8'd232 + 8'(gk) : cube;
        end
    end

    tcs_pkg::t_out_word r_out;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.cell_kind    <= r_s5_kind;
            r_out.fill_mask    <= r_s5_mask;
            r_out.corner_glyph <= r_s5_cor;
            r_out.fore_colour  <= r_s5_f;
            r_out.back_colour  <= r_s5_b;
            r_out.fore_palette <= (r_s5_kind == tcs_pkg::KIND_BLANK) ? 8'd0 : n_s6_pal[0];
            r_out.back_palette <= (r_s5_kind == tcs_pkg::KIND_SPLIT) ? n_s6_pal[1] : 8'd0;
        end
    end

    assign o_cell.valid = r_vld[tcs_pkg::NumStages-1];
    assign o_cell.data  = r_out;

    `TCS_ASSERT(a_hold, i_clk, i_rst_n, o_cell.valid && !o_cell.ready |=> $stable(r_out))
    `TCS_ASSERT(a_stall, i_clk, i_rst_n, o_cell.valid && !o_cell.ready |-> !i_cell.ready)
    `TCS_ASSERT(a_blank, i_clk, i_rst_n, o_cell.valid && o_cell.data.cell_kind == tcs_pkg::KIND_BLANK |-> o_cell.data.fill_mask == '0 && o_cell.data.fore_palette == '0)
    `TCS_ASSERT_ALWAYS(a_rst, i_clk, !$past(i_rst_n) |-> !o_cell.valid)
endmodule

@@ tb/tcs_cell_checker.sv @@
`timescale 1ns / 1ps
module tcs_cell_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_style_we,
    input  logic [1:0] i_style_wdata,
    tcs_in_if          i_cell,
    tcs_out_if         o_cell,
    output int         o_fail_count,
    output int         o_pending
);
    import tcs_pkg::*;

    localparam int Level [6] = '{0, 95, 135, 175, 215, 255};

    logic [1:0] style_q;
    t_out_word  split_q[$];

    assign o_pending = split_q.size();

    function automatic int sq(input int a, input int b);
        return (a - b) * (a - b);
    endfunction

    function automatic int level_of(input int v);
        int best;
        int best_d;
        best = 0;
        best_d = 65536;
        for (int i = 0; i < 6; i++) begin
            if (sq(v, Level[i]) < best_d) begin
                best_d = sq(v, Level[i]);
                best = i;
            end
        end
        return best;
    endfunction

    function automatic logic [7:0] xterm_index(input t_rgb c);
        int r, g, b, ri, gi, bi, gray, k, dc;
        r = c[23:16];
        g = c[15:8];
        b = c[7:0];
        ri = level_of(r);
        gi = level_of(g);
        bi = level_of(b);
        if ((r > g ? r - g : g - r) < 8 && (g > b ? g - b : b - g) < 8) begin
            gray = (r + g + b) / 3;
            k = (gray < 8) ? 0 : (gray - 8) / 10;
            if (k > 23) k = 23;
            dc = sq(r, Level[ri]) + sq(g, Level[gi]) + sq(b, Level[bi]);
            if (3 * sq(gray, 8 + 10 * k) < dc) return 8'(232 + k);
        end
        return 8'(16 + 36 * ri + 6 * gi + bi);
    endfunction

    function automatic int luma_of(input t_pix p);
        return 30 * p[23:16] + 59 * p[15:8] + 11 * p[7:0];
    endfunction

    function automatic int gap(input t_pix a, input t_pix b);
        return sq(a[23:16], b[23:16]) + sq(a[15:8], b[15:8]) + sq(a[7:0], b[7:0]);
    endfunction

    function automatic t_out_word split_cell(input t_in_word w, input logic [1:0] st);
        t_out_word o;
        int n, n_tr, hi, lo, side;
        int sr[2], sg[2], sb[2], cnt[2];
        t_rgb sf, sbk, t;
        logic [5:0] m;
        o = '0;
        m = '0;
        n = (st == STYLE_SEXT) ? 6 : 4;
        n_tr = 0;
        sr = '{0, 0}; sg = '{0, 0}; sb = '{0, 0}; cnt = '{0, 0};
        for (int i = 0; i < n; i++) if (w.sub_pixel[i][24]) n_tr++;
        if (n_tr == n) begin
            o.cell_kind = KIND_BLANK;
        end else if (n_tr > 0) begin
            for (int i = 0; i < n; i++) begin
                if (!w.sub_pixel[i][24]) begin
                    m[i] = 1'b1;
                    sr[1] += w.sub_pixel[i][23:16];
                    sg[1] += w.sub_pixel[i][15:8];
                    sb[1] += w.sub_pixel[i][7:0];
                    cnt[1]++;
                end
            end
            o.cell_kind = KIND_MIXED;
            o.fill_mask = m;
            o.fore_colour = {8'(sr[1] / cnt[1]), 8'(sg[1] / cnt[1]), 8'(sb[1] / cnt[1])};
            o.fore_palette = xterm_index(o.fore_colour);
        end else begin
            hi = 0;
            lo = 0;
            for (int i = 1; i < n; i++) begin
                if (luma_of(w.sub_pixel[i]) > luma_of(w.sub_pixel[hi])) hi = i;
                if (luma_of(w.sub_pixel[i]) < luma_of(w.sub_pixel[lo])) lo = i;
            end
            sf = w.sub_pixel[hi][23:0];
            sbk = w.sub_pixel[lo][23:0];
            o.fore_colour = sf;
            o.back_colour = sbk;
            for (int i = 0; i < n; i++) begin
                side = (gap(w.sub_pixel[i], {1'b0, sf}) < gap(w.sub_pixel[i], {1'b0, sbk}))
                       ? 1 : 0;
                m[i] = side[0];
                sr[side] += w.sub_pixel[i][23:16];
                sg[side] += w.sub_pixel[i][15:8];
                sb[side] += w.sub_pixel[i][7:0];
                cnt[side]++;
            end
            if (cnt[0] > 0)
                o.back_colour = {8'(sr[0] / cnt[0]), 8'(sg[0] / cnt[0]), 8'(sb[0] / cnt[0])};
            if (cnt[1] > 0)
                o.fore_colour = {8'(sr[1] / cnt[1]), 8'(sg[1] / cnt[1]), 8'(sb[1] / cnt[1])};
            if (st == STYLE_TRI) begin
                if (m inside {6'd1, 6'd2, 6'd4, 6'd8, 6'd7, 6'd11, 6'd13, 6'd14})
                    o.corner_glyph = 1'b1;
                // lone background corner: colours trade places
                if (m inside {6'd7, 6'd11, 6'd13, 6'd14}) begin
                    t = o.fore_colour;
                    o.fore_colour = o.back_colour;
                    o.back_colour = t;
                end
            end
            o.cell_kind = KIND_SPLIT;
            o.fill_mask = m;
            o.fore_palette = xterm_index(o.fore_colour);
            o.back_palette = xterm_index(o.back_colour);
        end
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_out_word e, a;
        if (!i_rst_n) begin
            style_q <= STYLE_QUAD;
            o_fail_count <= 0;
            split_q.delete();
        end else begin
            if (i_style_we) style_q <= i_style_wdata;
            if (i_cell.valid && i_cell.ready)
                split_q.push_back(split_cell(i_cell.data, style_q));
            if (o_cell.valid && o_cell.ready) begin
                a = o_cell.data;
                if (split_q.size() == 0) begin
                    $error("output word with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = split_q.pop_front();
                    if (a != e) begin
                        o_fail_count <= o_fail_count + 1;
                        if (a.cell_kind != e.cell_kind)
                            $error("cell_kind exp %0d got %0d", e.cell_kind, a.cell_kind);
                        if (a.fill_mask != e.fill_mask)
                            $error("fill_mask exp %0d got %0d", e.fill_mask, a.fill_mask);
                        if (a.corner_glyph != e.corner_glyph)
                            $error("corner_glyph exp %0d got %0d",
                                   e.corner_glyph, a.corner_glyph);
                        if (a.fore_colour != e.fore_colour)
                            $error("fore_colour exp %h got %h", e.fore_colour, a.fore_colour);
                        if (a.back_colour != e.back_colour)
                            $error("back_colour exp %h got %h", e.back_colour, a.back_colour);
                        if (a.fore_palette != e.fore_palette)
                            $error("fore_palette exp %0d got %0d",
                                   e.fore_palette, a.fore_palette);
                        if (a.back_palette != e.back_palette)
                            $error("back_palette exp %0d got %0d",
                                   e.back_palette, a.back_palette);
                    end
                end
            end
        end
    end
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import tcs_pkg::*;

    localparam int CycleLimit = 400000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       style_we = 1'b0;
    logic [1:0] style_wdata = STYLE_QUAD;
    int         sender_idle = 0;
    int         receiver_stall = 0;
    bit         hold_off = 1'b0;
    int         fail_count;
    int         pending;
    int         cycles = 0;

    tcs_in_if  cell_in ();
    tcs_out_if cell_out ();

    two_colour_cell_split DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_style_we    (style_we),
        .i_style_wdata (style_wdata),
        .i_cell        (cell_in.sink),
        .o_cell        (cell_out.source)
    );

    tcs_cell_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_style_we    (style_we),
        .i_style_wdata (style_wdata),
        .i_cell        (cell_in),
        .o_cell        (cell_out),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        cell_in.valid = 1'b0;
        cell_in.data = '0;
        cell_out.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stall, or held off for a long stretch
    always @(negedge i_clk) begin
        if (hold_off) cell_out.ready <= 1'b0;
        else cell_out.ready <= ($urandom_range(99) >= receiver_stall);
    end

    function automatic t_pix rand_pix(input int tr_pct);
        t_pix p;
        p = 25'($urandom);
        p[24] = ($urandom_range(99) < tr_pct);
        return p;
    endfunction

    task automatic send_cell(input t_in_word w);
        while ($urandom_range(99) < sender_idle) begin
            cell_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        cell_in.valid <= 1'b1;
        cell_in.data <= w;
        @(posedge i_clk);
        while (!cell_in.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic finish_phase();
        cell_in.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_style(input logic [1:0] s);
        style_we <= 1'b1;
        style_wdata <= s;
        @(negedge i_clk);
        style_we <= 1'b0;
    endtask

    task automatic random_cells(input int count);
        t_in_word w;
        int mode;
        for (int i = 0; i < count; i++) begin
            mode = $urandom_range(9);
            for (int j = 0; j < NumPix; j++) begin
                case (mode)
                    0: w.sub_pixel[j] = rand_pix(100);
                    1, 2: w.sub_pixel[j] = rand_pix(40);
                    // near-grey cells reach the grey ramp
                    3: begin
                        w.sub_pixel[j] = rand_pix(0);
                        w.sub_pixel[j][15:8] = w.sub_pixel[j][23:16] ^ 8'($urandom_range(3));
                        w.sub_pixel[j][7:0] = w.sub_pixel[j][23:16] ^ 8'($urandom_range(3));
                    end
                    4: w.sub_pixel[j] = (j == 0 || $urandom_range(1)) ? 25'h0F0F0F : 25'hE0E0E0;
                    default: w.sub_pixel[j] = rand_pix(0);
                endcase
            end
            if (mode == 4) w.sub_pixel[$urandom_range(3)] = rand_pix(0);
            send_cell(w);
        end
    endtask

    initial begin
        t_in_word w;
        logic [1:0] styles [5] = '{STYLE_QUAD, STYLE_TRI, STYLE_SEXT, 2'd3, STYLE_TRI};
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed cells in every style
        for (int s = 0; s < 4; s++) begin
            write_style(2'(s));
            w = '0;
            for (int j = 0; j < NumPix; j++) w.sub_pixel[j] = 25'h1FFFFFF;
            send_cell(w);
            w.sub_pixel[0] = 25'h0FFFFFF;
            send_cell(w);
            for (int j = 0; j < NumPix; j++) w.sub_pixel[j] = 25'h0808080;
            send_cell(w);
            w.sub_pixel[2] = 25'h0FFFFFF;
            send_cell(w);
            w.sub_pixel[0] = 25'h0000000;
            w.sub_pixel[3] = 25'h0FFFFFF;
            send_cell(w);
            finish_phase();
        end

        // long hold-off while the sender keeps offering
        write_style(STYLE_SEXT);
        hold_off = 1'b1;
        fork
            random_cells(30);
            begin
                repeat (60) @(negedge i_clk);
                hold_off = 1'b0;
            end
        join
        finish_phase();

        for (int ph = 0; ph < 4; ph++) begin
            sender_idle = (ph == 1 || ph == 3) ? ((ph == 3) ? 25 : 69) : 0;
            receiver_stall = (ph == 2) ? 69 : ((ph == 3) ? 25 : 0);
            for (int s = 0; s < 5; s++) begin
                write_style(styles[s]);
                random_cells(55);
                finish_phase();
            end
        end

        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule

@@ two_colour_cell_split.f @@
+incdir+rtl
rtl/tcs_pkg.sv
rtl/tcs_if.sv
rtl/two_colour_cell_split.sv
tb/tcs_cell_checker.sv
tb/tb_top.sv
